// ===== rtl/core/versioned_key_table_assert.svh =====
// assertion macros for the versioned key table
`ifndef VERSIONED_KEY_TABLE_ASSERT_SVH
`define VERSIONED_KEY_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define VKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vkt check failed");
`define VKT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vkt check failed");
`else
`define VKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VKT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/vkt_pkg.sv =====
package vkt_pkg;

    localparam int DEF_TABLE_SLOTS = 16;
    localparam int MAX_RESULTS     = 16;

    localparam int ACT_W      = 3;
    localparam int KEY_W      = 32;
    localparam int VER_W      = 8;
    localparam int PAY_W      = 32;
    localparam int STAT_W     = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int ENTRY_W    = KEY_W + VER_W + PAY_W;

    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEL_KEY    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DEL_VER    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PRUNE      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEARCH_KEY = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SEARCH_VER = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_KEY   = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             bad_key;
        logic [KEY_W-1:0] key;
        logic [VER_W-1:0] version;
        logic [PAY_W-1:0] payload;
    } cmd_t;

    typedef struct packed {
        logic                  valid;
        logic [STAT_W-1:0]     status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [KEY_W-1:0]      key;
        logic [VER_W-1:0]      version;
        logic [PAY_W-1:0]      payload;
        logic                  last;
    } res_t;

endpackage

// ===== rtl/core/vkt_ram.sv =====
module vkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/vkt_front.sv =====
module vkt_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [vkt_pkg::ACT_W-1:0]  action,
    input  logic [vkt_pkg::KEY_W-1:0]  key,
    input  logic [vkt_pkg::VER_W-1:0]  version,
    input  logic [vkt_pkg::PAY_W-1:0]  payload,
    output logic                       cmd_valid,
    output vkt_pkg::cmd_t              cmd,
    input  logic                       pop
);

    vkt_pkg::cmd_t q_reg [2];
    vkt_pkg::cmd_t cmd_in;
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          legal;
    logic          push;

    always_comb
    begin
        case (action) inside
            vkt_pkg::ACT_INSERT, vkt_pkg::ACT_DEL_KEY, vkt_pkg::ACT_DEL_VER,
            vkt_pkg::ACT_PRUNE, vkt_pkg::ACT_SEARCH_KEY, vkt_pkg::ACT_SEARCH_VER:
                legal = 1'b1;
            default:
                legal = 1'b0;
        endcase
    end

    assign busy = (cnt_reg == 2'd2);
    // unused action codes are dropped here and never reach the back end
    assign push = start && !busy && legal;

    always_comb
    begin
        cmd_in.action  = action;
        cmd_in.bad_key = (action == vkt_pkg::ACT_INSERT) && (key == '0);
        cmd_in.key     = key;
        cmd_in.version = version;
        cmd_in.payload = payload;
    end

    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/core/vkt_back.sv =====
module vkt_back #(
    parameter int TABLE_SLOTS = vkt_pkg::DEF_TABLE_SLOTS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  vkt_pkg::cmd_t cmd,
    output logic          pop,
    output vkt_pkg::res_t res
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int CW = SW + 1;
    localparam int NW = $clog2(vkt_pkg::MAX_RESULTS + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_FINISH  = 6'b000100,
        S_PJ_RD   = 6'b001000,
        S_PJ_CAP  = 6'b010000,
        S_PI_SCAN = 6'b100000
    } state_t;

    function automatic vkt_pkg::res_t mk_res(
        input logic [vkt_pkg::STAT_W-1:0] status,
        input logic [SW-1:0]              slot,
        input logic [vkt_pkg::KEY_W-1:0]  key,
        input logic [vkt_pkg::VER_W-1:0]  version,
        input logic [vkt_pkg::PAY_W-1:0]  payload,
        input logic                       last
    );
        vkt_pkg::res_t r;
        r.valid   = 1'b1;
        r.status  = status;
        r.slot    = vkt_pkg::SLOT_OUT_W'(slot);
        r.key     = key;
        r.version = version;
        r.payload = payload;
        r.last    = last;
        return r;
    endfunction

    state_t                     state_reg, state_next;
    vkt_pkg::cmd_t              op_reg, op_next;
    logic [TABLE_SLOTS-1:0]     valid_reg, valid_next;
    logic [CW-1:0]              iss_reg, iss_next;
    logic                       rd_v_reg, rd_v_next;
    logic [SW-1:0]              rd_idx_reg, rd_idx_next;
    logic                       hit_v_reg, hit_v_next;
    logic [SW-1:0]              hit_reg, hit_next;
    logic [vkt_pkg::VER_W-1:0]  hit_ver_reg, hit_ver_next;
    logic [vkt_pkg::PAY_W-1:0]  hit_pay_reg, hit_pay_next;
    logic [vkt_pkg::VER_W-1:0]  cnt_reg, cnt_next;
    logic                       pend_v_reg, pend_v_next;
    logic [SW-1:0]              pend_slot_reg, pend_slot_next;
    logic [vkt_pkg::VER_W-1:0]  pend_ver_reg, pend_ver_next;
    logic [vkt_pkg::PAY_W-1:0]  pend_pay_reg, pend_pay_next;
    logic [NW-1:0]              n_reg, n_next;
    logic [CW-1:0]              j_reg, j_next;
    logic [vkt_pkg::KEY_W-1:0]  kj_reg, kj_next;
    logic [vkt_pkg::VER_W-1:0]  vj_reg, vj_next;
    vkt_pkg::res_t              res_reg, res_next;

    logic                       ram_we;
    logic [SW-1:0]              ram_waddr;
    logic [vkt_pkg::ENTRY_W-1:0] ram_wdata;
    logic [SW-1:0]              ram_raddr;
    logic [vkt_pkg::ENTRY_W-1:0] ram_rdata;

    logic [vkt_pkg::KEY_W-1:0]  e_key;
    logic [vkt_pkg::VER_W-1:0]  e_ver;
    logic [vkt_pkg::PAY_W-1:0]  e_pay;
    logic                       e_valid;
    logic                       key_hit;
    logic                       ver_hit;
    logic                       scan_end;
    logic [NW-1:0]              n_after;
    logic [vkt_pkg::VER_W-1:0]  new_ver;

    vkt_ram #(
        .WIDTH (vkt_pkg::ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign e_key    = ram_rdata[vkt_pkg::ENTRY_W-1 -: vkt_pkg::KEY_W];
    assign e_ver    = ram_rdata[vkt_pkg::PAY_W +: vkt_pkg::VER_W];
    assign e_pay    = ram_rdata[vkt_pkg::PAY_W-1:0];
    assign e_valid  = valid_reg[rd_idx_reg];
    assign key_hit  = rd_v_reg && e_valid && (e_key == op_reg.key);
    assign ver_hit  = key_hit && (e_ver == op_reg.version);
    assign scan_end = rd_v_reg && (rd_idx_reg == SW'(TABLE_SLOTS - 1));
    assign n_after  = n_reg + NW'(pend_v_reg);
    assign new_ver  = cnt_reg + 8'd1;

    assign ram_raddr = (state_reg == S_PJ_RD) ? j_reg[SW-1:0] : iss_reg[SW-1:0];
    assign ram_waddr = hit_reg;
    assign ram_wdata = {op_reg.key, new_ver, op_reg.payload};
    assign ram_we    = (state_reg == S_FINISH) && (op_reg.action == vkt_pkg::ACT_INSERT)
                       && hit_v_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        valid_next     = valid_reg;
        iss_next       = iss_reg;
        rd_v_next      = 1'b0;
        rd_idx_next    = rd_idx_reg;
        hit_v_next     = hit_v_reg;
        hit_next       = hit_reg;
        hit_ver_next   = hit_ver_reg;
        hit_pay_next   = hit_pay_reg;
        cnt_next       = cnt_reg;
        pend_v_next    = pend_v_reg;
        pend_slot_next = pend_slot_reg;
        pend_ver_next  = pend_ver_reg;
        pend_pay_next  = pend_pay_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        kj_next        = kj_reg;
        vj_next        = vj_reg;
        res_next       = '0;
        pop            = 1'b0;

        // the read issue pipeline is shared by the plain scan and the prune inner scan
        if ((state_reg == S_SCAN) || (state_reg == S_PI_SCAN))
        begin
            if (iss_reg < CW'(TABLE_SLOTS))
            begin
                rd_v_next   = 1'b1;
                rd_idx_next = iss_reg[SW-1:0];
                iss_next    = iss_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop         = 1'b1;
                    op_next     = cmd;
                    iss_next    = '0;
                    hit_v_next  = 1'b0;
                    cnt_next    = '0;
                    pend_v_next = 1'b0;
                    n_next      = '0;
                    j_next      = '0;
                    if (cmd.bad_key)
                    begin
                        res_next = mk_res(vkt_pkg::ST_BAD_KEY, '0, '0, '0, '0, 1'b1);
                    end
                    else if (cmd.action == vkt_pkg::ACT_PRUNE)
                    begin
                        state_next = S_PJ_RD;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                case (op_reg.action)
                    vkt_pkg::ACT_INSERT:
                    begin
                        if (rd_v_reg && !e_valid && !hit_v_reg)
                        begin
                            hit_v_next = 1'b1;
                            hit_next   = rd_idx_reg;
                        end
                        if (key_hit)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    vkt_pkg::ACT_DEL_KEY:
                    begin
                        if (key_hit)
                        begin
                            valid_next[rd_idx_reg] = 1'b0;
                            if (!hit_v_reg)
                            begin
                                hit_v_next = 1'b1;
                                hit_next   = rd_idx_reg;
                            end
                        end
                    end
                    vkt_pkg::ACT_SEARCH_KEY:
                    begin
                        if (key_hit)
                        begin
                            // hold one match back so the final one can carry last
                            if (pend_v_reg)
                            begin
                                res_next = mk_res(vkt_pkg::ST_OK, pend_slot_reg, op_reg.key,
                                                  pend_ver_reg, pend_pay_reg, 1'b0);
                            end
                            n_next         = n_after;
                            pend_v_next    = 1'b1;
                            pend_slot_next = rd_idx_reg;
                            pend_ver_next  = e_ver;
                            pend_pay_next  = e_pay;
                        end
                    end
                    default:
                    begin
                        if (ver_hit && !hit_v_reg)
                        begin
                            hit_v_next   = 1'b1;
                            hit_next     = rd_idx_reg;
                            hit_ver_next = e_ver;
                            hit_pay_next = e_pay;
                        end
                    end
                endcase
                if (scan_end ||
                    (key_hit && (op_reg.action == vkt_pkg::ACT_SEARCH_KEY) &&
                     (n_after == NW'(vkt_pkg::MAX_RESULTS - 1))))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
                case (op_reg.action)
                    vkt_pkg::ACT_INSERT:
                    begin
                        if (hit_v_reg)
                        begin
                            valid_next[hit_reg] = 1'b1;
                            res_next = mk_res(vkt_pkg::ST_OK, hit_reg, op_reg.key, new_ver,
                                              op_reg.payload, 1'b1);
                        end
                        else
                        begin
                            res_next = mk_res(vkt_pkg::ST_FULL, '0, op_reg.key, '0, '0, 1'b1);
                        end
                    end
                    vkt_pkg::ACT_DEL_KEY:
                    begin
                        if (hit_v_reg)
                        begin
                            res_next = mk_res(vkt_pkg::ST_OK, hit_reg, op_reg.key, '0, '0,
                                              1'b1);
                        end
                        else
                        begin
                            res_next = mk_res(vkt_pkg::ST_NOT_FOUND, '0, op_reg.key,
                                              op_reg.version, '0, 1'b1);
                        end
                    end
                    vkt_pkg::ACT_SEARCH_KEY:
                    begin
                        if (pend_v_reg)
                        begin
                            res_next = mk_res(vkt_pkg::ST_OK, pend_slot_reg, op_reg.key,
                                              pend_ver_reg, pend_pay_reg, 1'b1);
                        end
                        else
                        begin
                            res_next = mk_res(vkt_pkg::ST_NOT_FOUND, '0, op_reg.key,
                                              op_reg.version, '0, 1'b1);
                        end
                    end
                    default:
                    begin
                        if (hit_v_reg)
                        begin
                            if (op_reg.action == vkt_pkg::ACT_DEL_VER)
                            begin
                                valid_next[hit_reg] = 1'b0;
                            end
                            res_next = mk_res(vkt_pkg::ST_OK, hit_reg, op_reg.key,
                                              hit_ver_reg, hit_pay_reg, 1'b1);
                        end
                        else
                        begin
                            res_next = mk_res(vkt_pkg::ST_NOT_FOUND, '0, op_reg.key,
                                              op_reg.version, '0, 1'b1);
                        end
                    end
                endcase
            end
            S_PJ_RD:
            begin
                if (j_reg == CW'(TABLE_SLOTS))
                begin
                    res_next   = mk_res(vkt_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
                    state_next = S_IDLE;
                end
                else if (!valid_reg[j_reg[SW-1:0]])
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    state_next = S_PJ_CAP;
                end
            end
            S_PJ_CAP:
            begin
                kj_next    = e_key;
                vj_next    = e_ver;
                iss_next   = '0;
                state_next = S_PI_SCAN;
            end
            S_PI_SCAN:
            begin
                // a newer version of the same key retires entry j
                if (rd_v_reg && e_valid && (e_key == kj_reg) && (e_ver > vj_reg))
                begin
                    valid_next[j_reg[SW-1:0]] = 1'b0;
                end
                if (scan_end)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_PJ_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            iss_reg    <= '0;
            rd_v_reg   <= 1'b0;
            hit_v_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
            n_reg      <= '0;
            j_reg      <= '0;
            cnt_reg    <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            iss_reg    <= iss_next;
            rd_v_reg   <= rd_v_next;
            hit_v_reg  <= hit_v_next;
            pend_v_reg <= pend_v_next;
            n_reg      <= n_next;
            j_reg      <= j_next;
            cnt_reg    <= cnt_next;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        rd_idx_reg    <= rd_idx_next;
        hit_reg       <= hit_next;
        hit_ver_reg   <= hit_ver_next;
        hit_pay_reg   <= hit_pay_next;
        pend_slot_reg <= pend_slot_next;
        pend_ver_reg  <= pend_ver_next;
        pend_pay_reg  <= pend_pay_next;
        kj_reg        <= kj_next;
        vj_reg        <= vj_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/versioned_key_table.sv =====
// insert, delete and search scan the table with one slot read per cycle from the entry ram
// search by key streams one result per matching slot during that scan, up to MAX_RESULTS
// prune runs a full scan of the table for each live entry
// two-deep command queue; the back end takes a new command only when the last one is done
// reset empties the table at once through per-slot valid bits; no clearing pass
`include "versioned_key_table_assert.svh"

module versioned_key_table #(
    parameter int TABLE_SLOTS = vkt_pkg::DEF_TABLE_SLOTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [vkt_pkg::ACT_W-1:0]         action,
    input  logic signed [vkt_pkg::KEY_W-1:0]  key,
    input  logic [vkt_pkg::VER_W-1:0]         version,
    input  logic [vkt_pkg::PAY_W-1:0]         payload,
    output logic                              result_valid,
    output logic [vkt_pkg::STAT_W-1:0]        status,
    output logic [vkt_pkg::SLOT_OUT_W-1:0]    slot,
    output logic signed [vkt_pkg::KEY_W-1:0]  found_key,
    output logic [vkt_pkg::VER_W-1:0]         found_version,
    output logic [vkt_pkg::PAY_W-1:0]         found_payload,
    output logic                              last
);

    logic          cmd_valid;
    vkt_pkg::cmd_t cmd;
    logic          pop;
    vkt_pkg::res_t res;

    vkt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .key       (key),
        .version   (version),
        .payload   (payload),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop)
    );

    vkt_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop),
        .res       (res)
    );

    assign result_valid  = res.valid;
    assign status        = res.status;
    assign slot          = res.slot;
    assign found_key     = res.key;
    assign found_version = res.version;
    assign found_payload = res.payload;
    assign last          = res.last;

    `VKT_ASSERT_IMP(a_err_is_last, clk, rst_n, result_valid && (status != vkt_pkg::ST_OK), last)
    `VKT_ASSERT_IMP(a_bad_key_zero, clk, rst_n, result_valid && (status == vkt_pkg::ST_BAD_KEY), (found_key == '0) && (slot == '0))
    `VKT_ASSERT_IMP(a_busy_has_cmd, clk, rst_n, busy, cmd_valid)
    `VKT_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, pop, cmd_valid)

endmodule
